// ===== design/gbn_pkg.sv =====
// ----------------------------------------------------------------------------
// Go-back-N window engine package
// Shared types and constants for the front end, the plan queue and the back
// end of the go-back-N window engine.
// ----------------------------------------------------------------------------
package gbn_pkg;

  localparam int unsigned SEQ_W       = 3;
  localparam int unsigned DATA_W      = 64;
  localparam int unsigned SEQ_MOD     = 8;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef logic [SEQ_W-1:0] seq_t;

  localparam seq_t MAX_SEQ = 3'd7;

  typedef enum logic [1:0] {
    CMD_PACKET    = 2'd0,
    CMD_ARRIVAL   = 2'd1,
    CMD_TIMEOUT   = 2'd2,
    CMD_CKSUM_ERR = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    RES_SEND    = 2'd0,
    RES_DELIVER = 2'd1,
    RES_STOP    = 2'd2,
    RES_STATUS  = 2'd3
  } result_e;

  typedef enum logic [1:0] {
    PLAN_SEND,
    PLAN_ARRIVAL,
    PLAN_RESEND,
    PLAN_STATUS
  } plan_e;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_e;

  typedef struct packed {
    plan_e             kind;
    seq_t              start;
    seq_t              ack;
    seq_t              count;
    logic              deliver;
    logic              refused;
    logic              net_en;
    logic [DATA_W-1:0] payload;
  } plan_t;

  typedef struct packed {
    logic              we;
    seq_t              addr;
    logic [DATA_W-1:0] data;
  } buf_wr_t;

  typedef struct packed {
    logic done_resend;
    logic resend_active;
  } back_status_t;

endpackage

// ===== design/go_back_n_window_engine.sv =====
// ----------------------------------------------------------------------------
// Go-back-N window engine
// Combined go-back-N sender and receiver, one event per input beat.
// ----------------------------------------------------------------------------
// The front end takes one event per cycle while the plan queue has room and
// hands a plan to the back end, which loads the plan and then emits the
// event's result beats one per cycle while the output is not stalled; a
// timeout can produce up to seven beats and a frame arrival up to eight. A
// packet-ready event is held off while a timeout's retransmissions are still
// queued or in progress, since those read the outbound buffer slots that new
// packets would write.
module go_back_n_window_engine import gbn_pkg::*; #(
  parameter int unsigned PacketBytes = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        command_i,
  input  logic [2:0]        frame_seq_i,
  input  logic [2:0]        frame_ack_i,
  input  logic [63:0]       payload_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        result_kind_o,
  output logic [2:0]        out_seq_o,
  output logic [2:0]        out_ack_o,
  output logic [63:0]       out_payload_o,
  output logic              refused_o,
  output logic              network_enable_o,
  output logic              last_o
);

  logic              push;
  plan_t             push_plan;
  logic              full;
  logic              pop;
  plan_t             pop_plan;
  logic              empty;
  buf_wr_t           buf_wr;
  back_status_t      back_status;
  seq_t              raddr;
  logic [DATA_W-1:0] rdata;

  gbn_front #(
    .PacketBytes(PacketBytes)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .frame_seq_i  (frame_seq_i),
    .frame_ack_i  (frame_ack_i),
    .payload_i    (payload_i),
    .push_o       (push),
    .plan_o       (push_plan),
    .full_i       (full),
    .buf_wr_o     (buf_wr),
    .back_status_i(back_status)
  );

  gbn_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_plan),
    .full_o     (full),
    .pop_i      (pop),
    .pop_data_o (pop_plan),
    .empty_o    (empty)
  );

  gbn_ram #(
    .Width(DATA_W),
    .Depth(SEQ_MOD)
  ) u_buf (
    .clk_i  (clk_i),
    .we_i   (buf_wr.we),
    .waddr_i(buf_wr.addr),
    .wdata_i(buf_wr.data),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  gbn_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .plan_i          (pop_plan),
    .empty_i         (empty),
    .pop_o           (pop),
    .raddr_o         (raddr),
    .rdata_i         (rdata),
    .status_o        (back_status),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .result_kind_o   (result_kind_o),
    .out_seq_o       (out_seq_o),
    .out_ack_o       (out_ack_o),
    .out_payload_o   (out_payload_o),
    .refused_o       (refused_o),
    .network_enable_o(network_enable_o),
    .last_o          (last_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      buf_wr.we |-> !back_status.resend_active)
    else $error("Outbound buffer written during a retransmission.");

endmodule

// ===== design/gbn_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and single read port with registered read data.
// ----------------------------------------------------------------------------
module gbn_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/gbn_fifo.sv =====
// ----------------------------------------------------------------------------
// Go-back-N plan queue
// Short queue of event plans between the front end and the back end.
// ----------------------------------------------------------------------------
module gbn_fifo import gbn_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  plan_t push_data_i,
  output logic  full_o,
  input  logic  pop_i,
  output plan_t pop_data_o,
  output logic  empty_o
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  plan_t           slot_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == CntW'(QUEUE_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    cnt_d = cnt_q + CntW'(push_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> (!full_o || pop_i))
    else $error("Plan queue pushed while full.");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o)
    else $error("Plan queue popped while empty.");

endmodule

// ===== design/gbn_front.sv =====
// ----------------------------------------------------------------------------
// Go-back-N front end
// Accepts events, updates the window state, writes the outbound buffer and
// queues one plan per event for the back end.
// ----------------------------------------------------------------------------
module gbn_front import gbn_pkg::*; #(
  parameter int unsigned PacketBytes = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          command_i,
  input  seq_t                frame_seq_i,
  input  seq_t                frame_ack_i,
  input  logic [DATA_W-1:0]   payload_i,
  output logic                push_o,
  output plan_t               plan_o,
  input  logic                full_i,
  output buf_wr_t             buf_wr_o,
  input  back_status_t        back_status_i
);

  localparam logic [DATA_W-1:0] PayMask = (PacketBytes >= 8) ? {DATA_W{1'b1}} :
      ((DATA_W'(1) << (8 * PacketBytes)) - DATA_W'(1));
  localparam int unsigned RsW = $clog2(QUEUE_DEPTH + 2);

  seq_t next_q, next_d;
  seq_t oldest_q, oldest_d;
  seq_t expected_q, expected_d;
  seq_t count_q, count_d;
  logic [RsW-1:0] resend_q, resend_d;

  logic              accept;
  logic [DATA_W-1:0] data;
  seq_t              ack_span;
  seq_t              retire;
  logic              match;
  plan_t             plan;
  logic              write_en;

  assign data       = payload_i & PayMask;
  assign in_ready_o = !full_i &&
                      !((command_i == CMD_PACKET) && (resend_q != '0));
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    next_d       = next_q;
    oldest_d     = oldest_q;
    expected_d   = expected_q;
    count_d      = count_q;
    write_en     = 1'b0;
    plan         = '0;
    plan.kind    = PLAN_STATUS;
    plan.ack     = expected_q + MAX_SEQ;
    plan.payload = data;
    match        = (frame_seq_i == expected_q);
    ack_span     = frame_ack_i - oldest_q;
    retire       = (ack_span < count_q) ? ack_span + seq_t'(1) : '0;
    case (cmd_e'(command_i))
      CMD_PACKET: begin
        if (count_q < MAX_SEQ) begin
          write_en   = 1'b1;
          plan.kind  = PLAN_SEND;
          plan.start = next_q;
          next_d     = next_q + seq_t'(1);
          count_d    = count_q + seq_t'(1);
        end else begin
          plan.refused = 1'b1;
        end
      end
      CMD_ARRIVAL: begin
        plan.start   = oldest_q;
        plan.count   = retire;
        plan.deliver = match;
        if (match) begin
          expected_d = expected_q + seq_t'(1);
        end
        oldest_d = oldest_q + retire;
        count_d  = count_q - retire;
        if (match || (retire != '0)) begin
          plan.kind = PLAN_ARRIVAL;
        end
      end
      CMD_TIMEOUT: begin
        if (count_q != '0) begin
          plan.kind  = PLAN_RESEND;
          plan.start = oldest_q;
          plan.count = count_q;
        end
      end
      default: begin
        plan.kind = PLAN_STATUS;
      end
    endcase
    plan.net_en = (count_d < MAX_SEQ);
    resend_d = resend_q + RsW'(accept && (plan.kind == PLAN_RESEND))
             - RsW'(back_status_i.done_resend);
  end

  assign push_o   = accept;
  assign plan_o   = plan;
  assign buf_wr_o = '{we: accept && write_en, addr: next_q, data: data};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_q     <= '0;
      oldest_q   <= '0;
      expected_q <= '0;
      count_q    <= '0;
      resend_q   <= '0;
    end else begin
      if (accept) begin
        next_q     <= next_d;
        oldest_q   <= oldest_d;
        expected_q <= expected_d;
        count_q    <= count_d;
      end
      resend_q <= resend_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) (next_q - oldest_q) == count_q)
    else $error("Window pointers disagree with the outstanding count.");

endmodule

// ===== design/gbn_back.sv =====
// ----------------------------------------------------------------------------
// Go-back-N back end
// Expands each queued plan into its result beats, one beat per cycle while the
// output is not stalled, and reads the outbound buffer for retransmissions.
// ----------------------------------------------------------------------------
module gbn_back import gbn_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  plan_t             plan_i,
  input  logic              empty_i,
  output logic              pop_o,
  output seq_t              raddr_o,
  input  logic [DATA_W-1:0] rdata_i,
  output back_status_t      status_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        result_kind_o,
  output seq_t              out_seq_o,
  output seq_t              out_ack_o,
  output logic [DATA_W-1:0] out_payload_o,
  output logic              refused_o,
  output logic              network_enable_o,
  output logic              last_o
);

  back_state_e state_q, state_d;
  plan_t       plan_q, plan_d;
  seq_t        seq_q, seq_d;
  seq_t        rem_q, rem_d;
  logic        dlv_q, dlv_d;
  logic        out_valid_q;

  logic              can_load;
  logic              load;
  result_e           res_kind;
  seq_t              res_seq;
  seq_t              res_ack;
  logic [DATA_W-1:0] res_data;
  logic              res_refused;
  logic              res_last;

  assign can_load = !out_valid_q || out_ready_i;

  always_comb begin
    res_kind    = RES_STATUS;
    res_seq     = '0;
    res_ack     = '0;
    res_data    = '0;
    res_refused = 1'b0;
    res_last    = 1'b1;
    case (plan_q.kind)
      PLAN_SEND: begin
        res_kind = RES_SEND;
        res_seq  = seq_q;
        res_ack  = plan_q.ack;
        res_data = plan_q.payload;
      end
      PLAN_ARRIVAL: begin
        if (dlv_q) begin
          res_kind = RES_DELIVER;
          res_data = plan_q.payload;
          res_last = (rem_q == '0);
        end else begin
          res_kind = RES_STOP;
          res_seq  = seq_q;
          res_last = (rem_q == seq_t'(1));
        end
      end
      PLAN_RESEND: begin
        res_kind = RES_SEND;
        res_seq  = seq_q;
        res_ack  = plan_q.ack;
        res_data = rdata_i;
        res_last = (rem_q == seq_t'(1));
      end
      default: begin
        res_refused = plan_q.refused;
      end
    endcase
  end

  always_comb begin
    state_d  = state_q;
    plan_d   = plan_q;
    seq_d    = seq_q;
    rem_d    = rem_q;
    dlv_d    = dlv_q;
    pop_o    = 1'b0;
    load     = 1'b0;
    status_o = '0;
    status_o.resend_active = (state_q == BK_RUN) && (plan_q.kind == PLAN_RESEND);
    case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          plan_d  = plan_i;
          seq_d   = plan_i.start;
          rem_d   = plan_i.count;
          dlv_d   = plan_i.deliver;
          state_d = BK_RUN;
        end
      end
      BK_RUN: begin
        if (can_load) begin
          load = 1'b1;
          if (dlv_q) begin
            dlv_d = 1'b0;
          end else begin
            seq_d = seq_q + seq_t'(1);
            rem_d = rem_q - seq_t'(1);
          end
          if (res_last) begin
            state_d              = BK_IDLE;
            status_o.done_resend = (plan_q.kind == PLAN_RESEND);
          end
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  assign raddr_o = seq_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= load || (out_valid_q && !out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    plan_q <= plan_d;
    seq_q  <= seq_d;
    rem_q  <= rem_d;
    dlv_q  <= dlv_d;
    if (load) begin
      result_kind_o    <= res_kind;
      out_seq_o        <= res_seq;
      out_ack_o        <= res_ack;
      out_payload_o    <= res_data;
      refused_o        <= res_refused;
      network_enable_o <= plan_q.net_en;
      last_o           <= res_last;
    end
  end

  assign out_valid_o = out_valid_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (state_q == BK_RUN) && (plan_q.kind == PLAN_RESEND) |-> rem_q != '0)
    else $error("Retransmission plan running with no frames left.");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Go-back-N window engine testbench
// Drives events into the engine and keeps its own copy of the sender and
// receiver state. Each accepted event yields a list of expected result beats,
// and every result beat is compared field by field with the oldest one.
// Covers corner events, random traffic under three idling mixes, and a long
// receiver stall that fills the engine.
// ----------------------------------------------------------------------------
module tb;
  import gbn_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200_000;
  localparam int unsigned STALL_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES = 20;

  typedef struct {
    result_e     kind;
    seq_t        seq;
    seq_t        ack;
    logic [63:0] data;
    logic        refused;
    logic        net_en;
    logic        last;
  } beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  command_i = '0;
  logic [2:0]  frame_seq_i = '0;
  logic [2:0]  frame_ack_i = '0;
  logic [63:0] payload_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  result_kind_o;
  logic [2:0]  out_seq_o;
  logic [2:0]  out_ack_o;
  logic [63:0] out_payload_o;
  logic        refused_o;
  logic        network_enable_o;
  logic        last_o;

  beat_t       expected_beats[$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned stall_requests = 0;
  int unsigned stall_served = 0;
  int unsigned stall_left = 0;

  seq_t        next_seq = '0;
  seq_t        oldest_seq = '0;
  seq_t        inbound_seq = '0;
  int unsigned in_flight = 0;
  logic [63:0] frame_store [SEQ_MOD];

  go_back_n_window_engine dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else if (stall_requests != stall_served) begin
      out_ready_i  <= 1'b0;
      stall_served <= stall_requests;
      stall_left   <= STALL_CYCLES;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  always @(posedge clk_i) begin
    beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_beats.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = expected_beats.pop_front();
        if (result_kind_o !== want.kind)
          report_mismatch($sformatf("result_kind %0d, want %0d", result_kind_o, want.kind));
        if (out_seq_o !== want.seq)
          report_mismatch($sformatf("out_seq %0d, want %0d", out_seq_o, want.seq));
        if (out_ack_o !== want.ack)
          report_mismatch($sformatf("out_ack %0d, want %0d", out_ack_o, want.ack));
        if (out_payload_o !== want.data)
          report_mismatch($sformatf("out_payload %h, want %h", out_payload_o, want.data));
        if (refused_o !== want.refused)
          report_mismatch($sformatf("refused %b, want %b", refused_o, want.refused));
        if (network_enable_o !== want.net_en)
          report_mismatch($sformatf("network_enable %b, want %b", network_enable_o,
                                    want.net_en));
        if (last_o !== want.last)
          report_mismatch($sformatf("last %b, want %b", last_o, want.last));
      end
    end
  end

  // True when x lies in [lo, hi) on the sequence circle.
  function automatic bit seq_between(seq_t lo, seq_t x, seq_t hi);
    return ((lo <= x) && (x < hi)) || ((hi < lo) && (lo <= x)) ||
           ((x < hi) && (hi < lo));
  endfunction

  function automatic beat_t make_beat(result_e kind, seq_t seq, seq_t ack,
                                      logic [63:0] data, logic refused);
    beat_t b;
    b.kind    = kind;
    b.seq     = seq;
    b.ack     = ack;
    b.data    = data;
    b.refused = refused;
    b.net_en  = 1'b0;
    b.last    = 1'b0;
    return b;
  endfunction

  task automatic predict_event(cmd_e cmd, seq_t fseq, seq_t fack, logic [63:0] data);
    beat_t beats[$];
    seq_t  piggy_ack;
    piggy_ack = inbound_seq + MAX_SEQ;
    case (cmd)
      CMD_PACKET: begin
        if (in_flight < MAX_SEQ) begin
          frame_store[next_seq] = data;
          in_flight++;
          beats.push_back(make_beat(RES_SEND, next_seq, piggy_ack, data, 1'b0));
          next_seq = next_seq + 3'd1;
        end else begin
          beats.push_back(make_beat(RES_STATUS, '0, '0, '0, 1'b1));
        end
      end
      CMD_ARRIVAL: begin
        if (fseq == inbound_seq) begin
          beats.push_back(make_beat(RES_DELIVER, '0, '0, data, 1'b0));
          inbound_seq = inbound_seq + 3'd1;
        end
        while (in_flight > 0 && seq_between(oldest_seq, fack, next_seq)) begin
          in_flight--;
          beats.push_back(make_beat(RES_STOP, oldest_seq, '0, '0, 1'b0));
          oldest_seq = oldest_seq + 3'd1;
        end
      end
      CMD_TIMEOUT: begin
        next_seq = oldest_seq;
        for (int unsigned i = 0; i < in_flight; i++) begin
          beats.push_back(make_beat(RES_SEND, next_seq, piggy_ack, frame_store[next_seq],
                                    1'b0));
          next_seq = next_seq + 3'd1;
        end
      end
      default: ;
    endcase
    if (beats.size() == 0)
      beats.push_back(make_beat(RES_STATUS, '0, '0, '0, 1'b0));
    foreach (beats[i]) begin
      beats[i].net_en = (in_flight < MAX_SEQ);
      beats[i].last   = (i == beats.size() - 1);
      expected_beats.push_back(beats[i]);
    end
  endtask

  task automatic send_event(cmd_e cmd, seq_t fseq, seq_t fack, logic [63:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    command_i   <= cmd;
    frame_seq_i <= fseq;
    frame_ack_i <= fack;
    payload_i   <= data;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_event(cmd, fseq, fack, data);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [63:0] random_payload();
    return {$urandom, $urandom};
  endfunction

  task automatic set_idling(int unsigned send_pct, int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // Mostly sensible traffic: in-order arrivals and acks that land inside the
  // window, with some stray frames, timeouts and checksum errors mixed in.
  task automatic random_traffic(int unsigned count);
    int unsigned pick;
    seq_t        fseq;
    seq_t        fack;
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      fseq = seq_t'($urandom_range(7));
      fack = seq_t'($urandom_range(7));
      if (pick < 40) begin
        send_event(CMD_PACKET, fseq, fack, random_payload());
      end else if (pick < 78) begin
        if ($urandom_range(9) < 7)
          fseq = inbound_seq;
        if (in_flight > 0 && $urandom_range(9) < 7)
          fack = oldest_seq + seq_t'($urandom_range(in_flight - 1));
        send_event(CMD_ARRIVAL, fseq, fack, random_payload());
      end else if (pick < 92) begin
        send_event(CMD_TIMEOUT, fseq, fack, random_payload());
      end else begin
        send_event(CMD_CKSUM_ERR, fseq, fack, random_payload());
      end
    end
  endtask

  task automatic test_corner_events();
    set_idling(9, 50);
    send_event(CMD_TIMEOUT, 3'd0, 3'd0, '0);
    send_event(CMD_CKSUM_ERR, 3'd7, 3'd7, '1);
    send_event(CMD_ARRIVAL, 3'd5, 3'd0, 64'h0123_4567_89ab_cdef);
    send_event(CMD_PACKET, 3'd0, 3'd0, '0);
    send_event(CMD_PACKET, 3'd7, 3'd7, '1);
    for (int i = 0; i < 5; i++)
      send_event(CMD_PACKET, 3'd0, 3'd0, random_payload());
    send_event(CMD_PACKET, 3'd0, 3'd0, random_payload());
    send_event(CMD_TIMEOUT, 3'd0, 3'd0, '0);
    send_event(CMD_ARRIVAL, inbound_seq, oldest_seq + 3'd2, 64'h5555_5555_5555_5555);
    send_event(CMD_ARRIVAL, inbound_seq + 3'd3, oldest_seq - 3'd1, random_payload());
    while (in_flight < MAX_SEQ)
      send_event(CMD_PACKET, 3'd0, 3'd0, random_payload());
    send_event(CMD_PACKET, 3'd0, 3'd0, random_payload());
    send_event(CMD_ARRIVAL, inbound_seq, next_seq - 3'd1, 64'haaaa_aaaa_aaaa_aaaa);
  endtask

  task automatic test_slow_receiver();
    set_idling(9, 50);
    random_traffic(160);
  endtask

  task automatic test_slow_sender();
    set_idling(50, 9);
    random_traffic(160);
  endtask

  task automatic test_full_rate();
    set_idling(0, 0);
    random_traffic(160);
  endtask

  task automatic test_backpressure();
    set_idling(0, 0);
    stall_requests++;
    random_traffic(40);
    drain_results();
    random_traffic(20);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_corner_events();
    test_slow_receiver();
    test_slow_sender();
    test_full_rate();
    test_backpressure();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/gbn_pkg.sv
design/gbn_ram.sv
design/gbn_fifo.sv
design/gbn_front.sv
design/gbn_back.sv
design/go_back_n_window_engine.sv
sim/tb.sv
